@@ src/lfdt_pkg.sv @@
package lfdt_pkg;

    localparam int DEF_MAX_DESCRIPTORS = 64;
    localparam int DEF_HANDLE_BITS     = 32;

    // The occupancy bitmap is searched one row at a time.
    localparam int ROW_BITS = 8;
    localparam int ROW_LOG  = 3;

    // Widest slot index over the supported capacity range (up to 1024 slots).
    localparam int SLOT_IDX_MAX_W = 10;

    typedef enum logic [1:0] {
        REQ_ASSIGN  = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_RESOLVE = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BADFD = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic                      set;
        logic                      clr;
        logic [SLOT_IDX_MAX_W-1:0] idx;
    } slot_upd_t;

endpackage

@@ src/lowest_free_descriptor_table_top.sv @@
// Channel   Dir  tdata                                          tuser
// s_*       in   [15:0] descriptor, [47:16] handle_in           [1:0] req_type
// m_*       out  [5:0] descriptor_out, [37:6] handle_out,       [1:0] status
//                [44:38] open_count_out
//
// In the accept cycle a request reads the handle memory and picks the lowest
// row of the occupancy bitmap with a free slot; in the execute state it finds
// the slot within that row, writes back and loads the output register.
// Reset clears the occupancy bits and the count at once; the handle memory is
// not cleared. A request waits in the execute state while the output register
// holds a beat that has not been taken.
module lowest_free_descriptor_table_top #(
    parameter int MAX_DESCRIPTORS = lfdt_pkg::DEF_MAX_DESCRIPTORS,
    parameter int HANDLE_BITS     = lfdt_pkg::DEF_HANDLE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // descriptor, handle_in
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // descriptor_out, handle_out, open_count_out
    output logic [1:0]  m_tuser    // status
);

    localparam int IDX_W = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
    localparam int CNT_W = $clog2(MAX_DESCRIPTORS + 1);
    localparam int ROWS  = (MAX_DESCRIPTORS + lfdt_pkg::ROW_BITS - 1) / lfdt_pkg::ROW_BITS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    lfdt_pkg::state_t   state_reg, state_next;
    lfdt_pkg::req_t     req_reg;
    logic               bad_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               m_valid_reg, m_valid_next;
    lfdt_pkg::status_t  status_reg, status_next;
    logic [5:0]         dout_reg, dout_next;
    logic [31:0]        hout_reg, hout_next;
    logic [6:0]         ocnt_reg, ocnt_next;
    logic               load_out;

    logic               accept;
    logic [HANDLE_BITS+31:0] handle_ext;
    logic               desc_bad;
    logic [IDX_W-1:0]   desc_idx;

    lfdt_pkg::slot_upd_t upd;
    logic               query_valid;
    logic [IDX_W-1:0]   free_idx;
    logic               ram_we;
    logic [HANDLE_BITS-1:0] ram_rdata;

    logic [IDX_W+5:0]       free_ext;
    logic [HANDLE_BITS+31:0] rdata_ext;
    logic [CNT_W+6:0]       cnt_ext;

    assign accept     = s_tvalid && s_tready;
    assign handle_ext = {{HANDLE_BITS{1'b0}}, s_tdata[47:16]};
    assign desc_idx   = s_tdata[IDX_W-1:0];
    assign desc_bad   = s_tdata[15] || ({1'b0, s_tdata[14:0]} >= 16'(MAX_DESCRIPTORS));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= lfdt_pkg::req_t'(s_tuser);
            bad_reg    <= desc_bad;
            idx_reg    <= desc_idx;
            handle_reg <= handle_ext[HANDLE_BITS-1:0];
        end
    end

    lfdt_handle_ram #(
        .DEPTH  (MAX_DESCRIPTORS),
        .DATA_W (HANDLE_BITS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata (handle_reg),
        .re    (accept),
        .raddr (desc_idx),
        .rdata (ram_rdata)
    );

    lfdt_slot_map #(
        .MAX_DESCRIPTORS (MAX_DESCRIPTORS),
        .IDX_W           (IDX_W),
        .ROWS            (ROWS),
        .ROW_W           (ROW_W)
    ) u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .search_en   (accept),
        .upd         (upd),
        .query_idx   (idx_reg),
        .query_valid (query_valid),
        .free_idx    (free_idx)
    );

    assign free_ext  = {6'b0, free_idx};
    assign rdata_ext = {32'b0, ram_rdata};

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        status_next  = status_reg;
        dout_next    = dout_reg;
        hout_next    = hout_reg;
        upd          = '0;
        ram_we       = 1'b0;
        load_out     = 1'b0;
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;

        case (state_reg)
            lfdt_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = lfdt_pkg::S_EXEC;
                end
            end
            lfdt_pkg::S_EXEC:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = lfdt_pkg::S_IDLE;
                    status_next  = lfdt_pkg::ST_OK;
                    dout_next    = '0;
                    hout_next    = '0;
                    case (req_reg)
                        lfdt_pkg::REQ_ASSIGN:
                        begin
                            if (cnt_reg < CNT_W'(MAX_DESCRIPTORS))
                            begin
                                dout_next = free_ext[5:0];
                                ram_we    = 1'b1;
                                upd.set   = 1'b1;
                                upd.idx[IDX_W-1:0] = free_idx;
                                cnt_next  = cnt_reg + CNT_W'(1);
                            end
                            else
                            begin
                                status_next = lfdt_pkg::ST_FULL;
                            end
                        end
                        lfdt_pkg::REQ_RELEASE,
                        lfdt_pkg::REQ_RESOLVE:
                        begin
                            if (!bad_reg && query_valid)
                            begin
                                hout_next = rdata_ext[31:0];
                                if (req_reg == lfdt_pkg::REQ_RELEASE)
                                begin
                                    upd.clr = 1'b1;
                                    upd.idx[IDX_W-1:0] = idx_reg;
                                    cnt_next = cnt_reg - CNT_W'(1);
                                end
                            end
                            else
                            begin
                                status_next = lfdt_pkg::ST_BADFD;
                            end
                        end
                        default:
                        begin
                            status_next = lfdt_pkg::ST_BADFD;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = lfdt_pkg::S_IDLE;
            end
        endcase

        cnt_ext   = {7'b0, cnt_next};
        ocnt_next = load_out ? cnt_ext[6:0] : ocnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lfdt_pkg::S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        dout_reg   <= dout_next;
        hout_reg   <= hout_next;
        ocnt_reg   <= ocnt_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, ocnt_reg, hout_reg, dout_reg};

endmodule

@@ src/lfdt_handle_ram.sv @@
module lfdt_handle_ram #(
    parameter int DEPTH  = lfdt_pkg::DEF_MAX_DESCRIPTORS,
    parameter int DATA_W = lfdt_pkg::DEF_HANDLE_BITS,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read, so a stalled request keeps it.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/lfdt_slot_map.sv @@
module lfdt_slot_map #(
    parameter int MAX_DESCRIPTORS = lfdt_pkg::DEF_MAX_DESCRIPTORS,
    parameter int IDX_W           = 6,
    parameter int ROWS            = 8,
    parameter int ROW_W           = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                search_en,
    input  lfdt_pkg::slot_upd_t upd,
    input  logic [IDX_W-1:0]    query_idx,
    output logic                query_valid,
    output logic [IDX_W-1:0]    free_idx
);

    localparam int PAD = ROWS * lfdt_pkg::ROW_BITS;

    logic [MAX_DESCRIPTORS-1:0]            valid_reg;
    logic [MAX_DESCRIPTORS-1:0]            valid_next;
    logic [PAD-1:0]                        padded;
    logic [ROWS-1:0]                       row_full;
    logic [ROW_W-1:0]                      first_row;
    logic [ROW_W-1:0]                      row_reg;
    logic [ROW_W+lfdt_pkg::ROW_LOG-1:0]    row_base;
    logic [lfdt_pkg::ROW_BITS-1:0]         row_bits;
    logic [lfdt_pkg::ROW_LOG-1:0]          bit_sel;
    logic [ROW_W+lfdt_pkg::ROW_LOG-1:0]    free_wide;

    // Slots past the capacity read as occupied so they are never handed out.
    always_comb
    begin
        padded = '1;
        padded[MAX_DESCRIPTORS-1:0] = valid_reg;
        for (int r = 0; r < ROWS; r++)
        begin
            row_full[r] = &padded[r*lfdt_pkg::ROW_BITS +: lfdt_pkg::ROW_BITS];
        end
    end

    always_comb
    begin
        first_row = '0;
        for (int r = ROWS - 1; r >= 0; r--)
        begin
            if (!row_full[r])
            begin
                first_row = ROW_W'(r);
            end
        end
    end

    // The row is picked in the accept cycle and registered; the bit is then picked from the registered row.
    always_ff @(posedge clk)
    begin
        if (search_en)
        begin
            row_reg <= first_row;
        end
    end

    always_comb
    begin
        row_base = {row_reg, {lfdt_pkg::ROW_LOG{1'b0}}};
        row_bits = padded[row_base +: lfdt_pkg::ROW_BITS];
        bit_sel  = '0;
        for (int b = lfdt_pkg::ROW_BITS - 1; b >= 0; b--)
        begin
            if (!row_bits[b])
            begin
                bit_sel = lfdt_pkg::ROW_LOG'(b);
            end
        end
        free_wide = {row_reg, bit_sel};
    end

    assign free_idx    = free_wide[IDX_W-1:0];
    assign query_valid = valid_reg[query_idx];

    always_comb
    begin
        valid_next = valid_reg;
        if (upd.set)
        begin
            valid_next[upd.idx[IDX_W-1:0]] = 1'b1;
        end
        if (upd.clr)
        begin
            valid_next[upd.idx[IDX_W-1:0]] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule
